### sv/assert_macros.svh
// assertion macros shared by the ramp bank modules
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DFRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define DFRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/dfrb_pkg.sv
// types and constants of the delayed fractional ramp bank
// used by dfrb_ctrl, dfrb_dpath and the top level
`default_nettype none

package dfrb_pkg;

  localparam int DATA_W  = 32;
  localparam int DELAY_W = 31;
  localparam int IDX_W   = 2;

  // thousandths carried into the value
  localparam int CARRY_UNIT = 1000;

  // floor(x/125) approximated as (x * RECIP_M) >> RECIP_SHIFT for x < 2**29,
  // low by at most one; sum/1000 == (sum>>3)/125
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_M = 30'd549755813;

  localparam int SUM_W  = DATA_W + 1;
  localparam int XW     = DATA_W - 3;
  localparam int PROD_W = XW + RECIP_W;
  localparam int QUO_W  = PROD_W - RECIP_SHIFT;
  localparam int REM_W  = 11;
  localparam int VAL_W  = DATA_W + 2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MULT,
    ST_REM,
    ST_FIX,
    ST_WRITE,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic delay_dec;
    logic sum_en;
    logic mult_en;
    logic rem_en;
    logic fix_en;
    logic write_en;
    logic report_en;
  } cmd_t;

  typedef struct packed {
    logic delay_nz;
    logic active;
    logic last_entry;
  } status_t;

endpackage

`default_nettype wire

### sv/dfrb_ctrl.sv
// sequencer of the ramp bank: handshakes, entry walk and output valid
// depends on dfrb_pkg and assert_macros.svh
`default_nettype none

module dfrb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            command_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dfrb_pkg::cmd_t       cmd_o,
  input  wire dfrb_pkg::status_t status_i
);
  import dfrb_pkg::*;

`include "assert_macros.svh"

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_room;

  assign accept   = in_valid_i && in_ready_o;
  assign out_room = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
            state_d          = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (status_i.delay_nz) begin
          cmd_o.delay_dec = 1'b1;
          state_d         = ST_REPORT;
        end else if (status_i.active) begin
          cmd_o.sum_en = 1'b1;
          state_d      = ST_MULT;
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_MULT: begin
        cmd_o.mult_en = 1'b1;
        state_d       = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem_en = 1'b1;
        state_d      = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix_en = 1'b1;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_en = 1'b1;
        state_d        = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_room) begin
          cmd_o.report_en = 1'b1;
          state_d         = status_i.last_entry ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register: the next entry is worked on while a result waits
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.report_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `DFRB_ASSERT(a_tick_leaves_idle, (accept && command_i == CMD_TICK) |=> !in_ready_o, "tick not started")
  `DFRB_ASSERT(a_active_goes_mult, (state_q == ST_FETCH && !status_i.delay_nz && status_i.active) |=> state_q == ST_MULT, "active entry skipped")
  `DFRB_ASSERT(a_last_ends_tick, (cmd_o.report_en && status_i.last_entry) |=> state_q == ST_IDLE, "tick did not end after last entry")
  `DFRB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> in_ready_o && !out_valid_o, "not idle in reset")

endmodule

`default_nettype wire

### sv/dfrb_dpath.sv
// datapath of the ramp bank: entry store, carry by 1000, clamp, result register
// depends on dfrb_pkg and assert_macros.svh
`default_nettype none

module dfrb_dpath #(
  parameter int ENTRY_COUNT = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dfrb_pkg::cmd_t                      cmd_i,
  output dfrb_pkg::status_t                        status_o,
  input  wire logic [dfrb_pkg::IDX_W-1:0]          entry_index_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_limit_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_value_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_step_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_accum_i,
  input  wire logic [dfrb_pkg::DELAY_W-1:0]        load_delay_i,
  output logic [dfrb_pkg::IDX_W-1:0]               report_index_o,
  output logic signed [dfrb_pkg::DATA_W-1:0]       current_value_o,
  output logic                                     still_ramping_o,
  output logic                                     still_delaying_o,
  output logic                                     last_report_o
);
  import dfrb_pkg::*;

`include "assert_macros.svh"

  // only entries a load can reach are stored; the rest stay zero for good
  localparam int LOADABLE    = 2 ** IDX_W;
  localparam int STORE_DEPTH = (ENTRY_COUNT < LOADABLE) ? ENTRY_COUNT : LOADABLE;
  localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = (ENTRY_COUNT > LOADABLE) ? $clog2(ENTRY_COUNT) : IDX_W;

  logic signed [DATA_W-1:0]  limit_q [STORE_DEPTH];
  logic signed [DATA_W-1:0]  value_q [STORE_DEPTH];
  logic signed [DATA_W-1:0]  step_q  [STORE_DEPTH];
  logic signed [DATA_W-1:0]  accum_q [STORE_DEPTH];
  logic        [DELAY_W-1:0] delay_q [STORE_DEPTH];

  logic [CNT_W-1:0]  cnt_q;
  logic [SIDX_W-1:0] sidx;
  logic [SIDX_W-1:0] load_sel;
  logic              in_store;
  logic              load_ok;

  logic signed [DATA_W-1:0]  cur_limit, cur_value, cur_step, cur_accum;
  logic        [DELAY_W-1:0] cur_delay;

  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic                    ge_unit_q;
  logic [PROD_W-1:0]       prod_q;
  logic [QUO_W-1:0]        q_est, q_q, q_fin_d, q_fin_q;
  logic [DATA_W-1:0]       qk;
  logic [REM_W-1:0]        rem_d, rem_q;
  logic [DATA_W-1:0]       acc_new_d, acc_new_q;
  logic signed [VAL_W-1:0] val_w;
  logic                    clamp;
  logic signed [DATA_W-1:0] new_value, new_step;

  assign sidx     = cnt_q[SIDX_W-1:0];
  assign load_sel = entry_index_i[SIDX_W-1:0];
  assign in_store = (32'(cnt_q) < 32'(STORE_DEPTH));
  assign load_ok  = (32'(entry_index_i) < 32'(STORE_DEPTH));

  always_comb begin
    cur_limit = '0;
    cur_value = '0;
    cur_step  = '0;
    cur_accum = '0;
    cur_delay = '0;
    if (in_store) begin
      cur_limit = limit_q[sidx];
      cur_value = value_q[sidx];
      cur_step  = step_q[sidx];
      cur_accum = accum_q[sidx];
      cur_delay = delay_q[sidx];
    end
  end

  assign status_o.delay_nz   = (cur_delay != '0);
  assign status_o.active     = (cur_step > 0) && (cur_value < cur_limit);
  assign status_o.last_entry = (32'(cnt_q) == 32'(ENTRY_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.tick_start) begin
      cnt_q <= '0;
    end else if (cmd_i.report_en) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // entry store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        limit_q[i] <= '0;
        value_q[i] <= '0;
        step_q[i]  <= '0;
        accum_q[i] <= '0;
        delay_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load && load_ok) begin
        limit_q[load_sel] <= load_limit_i;
        value_q[load_sel] <= load_value_i;
        step_q[load_sel]  <= load_step_i;
        accum_q[load_sel] <= load_accum_i;
        delay_q[load_sel] <= load_delay_i;
      end
      if (cmd_i.delay_dec && in_store) begin
        delay_q[sidx] <= cur_delay - DELAY_W'(1);
      end
      if (cmd_i.write_en && in_store) begin
        value_q[sidx] <= new_value;
        step_q[sidx]  <= new_step;
        accum_q[sidx] <= acc_new_q;
      end
    end
  end

  // carry pipeline: sum, reciprocal multiply, remainder, one correction
  assign sum_d   = SUM_W'(cur_accum) + SUM_W'(cur_step);
  assign q_est   = prod_q[RECIP_SHIFT +: QUO_W];
  assign qk      = DATA_W'(DATA_W'(q_est) * DATA_W'(CARRY_UNIT));
  assign rem_d   = REM_W'(sum_q[DATA_W-1:0] - qk);

  always_comb begin
    q_fin_d   = '0;
    acc_new_d = sum_q[DATA_W-1:0];
    if (ge_unit_q) begin
      if (rem_q >= REM_W'(CARRY_UNIT)) begin
        q_fin_d   = q_q + QUO_W'(1);
        acc_new_d = DATA_W'(rem_q - REM_W'(CARRY_UNIT));
      end else begin
        q_fin_d   = q_q;
        acc_new_d = DATA_W'(rem_q);
      end
    end
  end

  assign val_w     = VAL_W'(cur_value) + $signed(VAL_W'(q_fin_q));
  assign clamp     = val_w > VAL_W'(cur_limit);
  assign new_value = clamp ? cur_limit : val_w[DATA_W-1:0];
  assign new_step  = clamp ? '0 : cur_step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q     <= sum_d;
      ge_unit_q <= (sum_d >= $signed(SUM_W'(CARRY_UNIT)));
    end
    if (cmd_i.mult_en) begin
      prod_q <= PROD_W'(sum_q[DATA_W-1:3]) * PROD_W'(RECIP_M);
    end
    if (cmd_i.rem_en) begin
      q_q   <= q_est;
      rem_q <= rem_d;
    end
    if (cmd_i.fix_en) begin
      q_fin_q   <= q_fin_d;
      acc_new_q <= acc_new_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.report_en) begin
      report_index_o   <= cnt_q[IDX_W-1:0];
      current_value_o  <= cur_value;
      still_ramping_o  <= status_o.active;
      still_delaying_o <= status_o.delay_nz;
      last_report_o    <= status_o.last_entry;
    end
  end

  `DFRB_ASSERT(a_rem_in_range, (cmd_i.fix_en && ge_unit_q) |=> acc_new_q < DATA_W'(CARRY_UNIT), "carry remainder out of range")
  `DFRB_ASSERT(a_quot_close, cmd_i.fix_en |-> !ge_unit_q || rem_q < REM_W'(2 * CARRY_UNIT), "quotient estimate off by more than one")
  `DFRB_ASSERT(a_write_active, cmd_i.write_en |-> status_o.active && !status_o.delay_nz, "write to an idle entry")

endmodule

`default_nettype wire

### sv/delayed_fractional_ramp_bank_top.sv
// Delayed fractional ramp bank, top level.
// Input channel (in_valid_i/in_ready_o): command_i = load writes one entry
// (limit, value, step, accumulator, delay) and gives no result; an index with
// no entry behind it is dropped. command_i = tick advances every entry and
// gives ENTRY_COUNT results in index order, the last one with last_report_o.
// Output channel (out_valid_o/out_ready_i) is a registered result stage.
// A load leaves the bank idle and ready for the next item. A tick walks the
// entries one at a time through a shared carry unit: a delayed or settled
// entry goes from fetch straight to report, a ramping one through sum,
// reciprocal multiply (1/125 of the sum shifted right by three), remainder,
// correction and write back. No new item is taken until the last result
// of a tick sits in the output register.
// A stalled receiver holds the current result; the next entry is still
// worked out and waits until the output register frees up.
// Reset clears every entry to zero and empties the output register.
// Depends on dfrb_pkg, dfrb_ctrl and dfrb_dpath.
`default_nettype none

module delayed_fractional_ramp_bank_top #(
  parameter int ENTRY_COUNT = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                command_i,
  input  wire logic [dfrb_pkg::IDX_W-1:0]          entry_index_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_limit_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_value_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_step_i,
  input  wire logic signed [dfrb_pkg::DATA_W-1:0]  load_accum_i,
  input  wire logic [dfrb_pkg::DELAY_W-1:0]        load_delay_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [dfrb_pkg::IDX_W-1:0]               report_index_o,
  output logic signed [dfrb_pkg::DATA_W-1:0]       current_value_o,
  output logic                                     still_ramping_o,
  output logic                                     still_delaying_o,
  output logic                                     last_report_o
);
  import dfrb_pkg::*;

  cmd_t    cmd;
  status_t status;

  dfrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dfrb_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .entry_index_i    (entry_index_i),
    .load_limit_i     (load_limit_i),
    .load_value_i     (load_value_i),
    .load_step_i      (load_step_i),
    .load_accum_i     (load_accum_i),
    .load_delay_i     (load_delay_i),
    .report_index_o   (report_index_o),
    .current_value_o  (current_value_o),
    .still_ramping_o  (still_ramping_o),
    .still_delaying_o (still_delaying_o),
    .last_report_o    (last_report_o)
  );

endmodule

`default_nettype wire

### bench/delayed_fractional_ramp_bank_top_tb.sv
`timescale 1ns / 1ps
// testbench for delayed_fractional_ramp_bank_top: loads and ticks with random idling,
// each entry report checked against an in-bench model of the ramp entries
// depends on dfrb_pkg and the ramp bank rtl

module delayed_fractional_ramp_bank_top_tb;
  import dfrb_pkg::*;

  localparam int ENTRIES     = 4;
  localparam int IDLE_PCT    = 13;
  localparam int RANDOM_GOAL = 250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic                    cmd;
    logic [IDX_W-1:0]        idx;
    int                      limit;
    int                      value;
    int                      step;
    int                      accum;
    logic [DELAY_W-1:0]      delay;
  } ramp_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    int               value;
    logic             ramping;
    logic             delaying;
    logic             last;
  } entry_report_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      command_i = CMD_TICK;
  logic [IDX_W-1:0]          entry_index_i = '0;
  logic signed [DATA_W-1:0]  load_limit_i = '0;
  logic signed [DATA_W-1:0]  load_value_i = '0;
  logic signed [DATA_W-1:0]  load_step_i = '0;
  logic signed [DATA_W-1:0]  load_accum_i = '0;
  logic [DELAY_W-1:0]        load_delay_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [IDX_W-1:0]          report_index_o;
  logic signed [DATA_W-1:0]  current_value_o;
  logic                      still_ramping_o;
  logic                      still_delaying_o;
  logic                      last_report_o;

  delayed_fractional_ramp_bank_top #(.ENTRY_COUNT(ENTRIES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .load_limit_i    (load_limit_i),
    .load_value_i    (load_value_i),
    .load_step_i     (load_step_i),
    .load_accum_i    (load_accum_i),
    .load_delay_i    (load_delay_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .report_index_o  (report_index_o),
    .current_value_o (current_value_o),
    .still_ramping_o (still_ramping_o),
    .still_delaying_o(still_delaying_o),
    .last_report_o   (last_report_o)
  );

  // model state of the four entries
  int                 limit_q [ENTRIES];
  int                 value_q [ENTRIES];
  int                 step_q  [ENTRIES];
  int                 accum_q [ENTRIES];
  logic [DELAY_W-1:0] delay_q [ENTRIES];

  ramp_item_t    pending_items[$];
  entry_report_t expected_reports[$];
  ramp_item_t    driven_item;
  ramp_item_t    next_item;

  int  items_taken = 0;
  int  loads_taken = 0;
  int  ticks_taken = 0;
  int  reports_checked = 0;
  int  errors = 0;
  int  cycle_count = 0;
  logic steady;

  // no idling on either side through a middle stretch of the run
  assign steady = (items_taken >= 120) && (items_taken < 180);

  always #1 clk_i = ~clk_i;

  function automatic ramp_item_t load_item(int idx, int lim, int val, int stp, int acc,
                                           logic [DELAY_W-1:0] dly);
    ramp_item_t it;
    it.cmd   = CMD_LOAD;
    it.idx   = idx[IDX_W-1:0];
    it.limit = lim;
    it.value = val;
    it.step  = stp;
    it.accum = acc;
    it.delay = dly;
    return it;
  endfunction

  // payload of a tick is don't-care, so it is random
  function automatic ramp_item_t tick_item();
    ramp_item_t it;
    it = load_item($urandom, $urandom, $urandom, $urandom, $urandom, DELAY_W'($urandom));
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic ramp_item_t random_ramp_load();
    int base;
    int stp;
    int acc;
    int dly;
    base = $signed($urandom) >>> 2;
    case ($urandom_range(0, 9))
      0:       stp = -int'($urandom_range(0, 1000));
      1:       stp = $urandom_range(100000, 5000000);
      default: stp = $urandom_range(1, 2500);
    endcase
    acc = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 5000)) : $urandom_range(0, 999);
    dly = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
    return load_item($urandom_range(0, 3), base + int'($urandom_range(0, 40)), base, stp, acc,
                     dly[DELAY_W-1:0]);
  endfunction

  // advance the bank model by one item and queue the reports it causes
  function automatic void apply_item(ramp_item_t it);
    longint        sum;
    longint        val;
    longint        quo;
    entry_report_t rep;
    if (it.cmd == CMD_LOAD) begin
      limit_q[it.idx] = it.limit;
      value_q[it.idx] = it.value;
      step_q[it.idx]  = it.step;
      accum_q[it.idx] = it.accum;
      delay_q[it.idx] = it.delay;
      loads_taken++;
      return;
    end
    ticks_taken++;
    for (int k = 0; k < ENTRIES; k++) begin
      if (delay_q[k] != 0) begin
        delay_q[k] = delay_q[k] - 1'b1;
      end else if (step_q[k] > 0 && value_q[k] < limit_q[k]) begin
        sum = longint'(accum_q[k]) + longint'(step_q[k]);
        val = longint'(value_q[k]);
        if (sum >= CARRY_UNIT) begin
          quo = sum / CARRY_UNIT;
          val += quo;
          sum -= quo * CARRY_UNIT;
        end
        accum_q[k] = int'(sum);
        // clamp keeps the leftover thousandths
        if (val > longint'(limit_q[k])) begin
          step_q[k] = 0;
          val = longint'(limit_q[k]);
        end
        value_q[k] = int'(val);
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      rep.idx      = k[IDX_W-1:0];
      rep.value    = value_q[k];
      rep.ramping  = (step_q[k] > 0) && (value_q[k] < limit_q[k]);
      rep.delaying = (delay_q[k] != 0);
      rep.last     = (k == ENTRIES - 1);
      expected_reports.push_back(rep);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_item(driven_item);
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_items.pop_front();
          driven_item = next_item;
          in_valid_i    <= 1'b1;
          command_i     <= next_item.cmd;
          entry_index_i <= next_item.idx;
          load_limit_i  <= next_item.limit;
          load_value_i  <= next_item.value;
          load_step_i   <= next_item.step;
          load_accum_i  <= next_item.accum;
          load_delay_i  <= next_item.delay;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    entry_report_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("report with nothing pending: report_index %0d current_value %0d",
                 report_index_o, current_value_o);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (report_index_o !== want.idx) begin
            $error("report_index: expected %0d, got %0d", want.idx, report_index_o);
            errors++;
          end
          if (current_value_o !== want.value) begin
            $error("current_value: expected %0d, got %0d", want.value, current_value_o);
            errors++;
          end
          if (still_ramping_o !== want.ramping) begin
            $error("still_ramping: expected %0b, got %0b", want.ramping, still_ramping_o);
            errors++;
          end
          if (still_delaying_o !== want.delaying) begin
            $error("still_delaying: expected %0b, got %0b", want.delaying, still_delaying_o);
            errors++;
          end
          if (last_report_o !== want.last) begin
            $error("last_report: expected %0b, got %0b", want.last, last_report_o);
            errors++;
          end
        end
      end
      out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("delayed_fractional_ramp_bank_top test failed");
      $finish;
    end
  end

  initial begin
    int random_items;
    int n;
    for (int k = 0; k < ENTRIES; k++) begin
      limit_q[k] = 0;
      value_q[k] = 0;
      step_q[k]  = 0;
      accum_q[k] = 0;
      delay_q[k] = '0;
    end

    // directed: reset state, carries, clamp, delays, inactive entries
    pending_items.push_back(tick_item());
    pending_items.push_back(load_item(0, 5, 0, 2500, 700, '0));
    // huge carry taken in one go
    pending_items.push_back(load_item(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      32'h7fffffff, '0));
    // passes the limit, clamped with remainder kept
    pending_items.push_back(load_item(2, 10, 9, 1999, 999, '0));
    // very negative accumulator sits behind a short delay
    pending_items.push_back(load_item(3, 100, 0, 5, 32'h80000000, 2));
    repeat (3) pending_items.push_back(tick_item());
    pending_items.push_back(load_item(0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, '0));
    // value already at or above the limit
    pending_items.push_back(load_item(1, 32'h80000000, 32'h7fffffff, 1, 0, '0));
    pending_items.push_back(load_item(2, 1000, 0, 1000, 0, '1));
    // exact carry lands on the limit, step survives
    pending_items.push_back(load_item(3, 1, 0, 1, 999, '0));
    repeat (2) pending_items.push_back(tick_item());
    pending_items.push_back(load_item(2, 32'h7fffffff, 32'h7ffffffe, 32'h7fffffff, 0, 1));
    pending_items.push_back(load_item(1, 0, -3, 0, 500, '0));
    repeat (3) pending_items.push_back(tick_item());

    // random: mostly load-then-tick runs, some noise
    random_items = 0;
    while (random_items < RANDOM_GOAL) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) == 0)
          pending_items.push_back(load_item($urandom, $urandom, $urandom, $urandom, $urandom,
                                            DELAY_W'($urandom)));
        else
          pending_items.push_back(tick_item());
        random_items++;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) pending_items.push_back(random_ramp_load());
        random_items += n;
        n = $urandom_range(1, 6);
        repeat (n) pending_items.push_back(tick_item());
        random_items += n;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d loads and %0d ticks, %0d entry reports compared",
             loads_taken, ticks_taken, reports_checked);
    if (errors == 0) begin
      $display("delayed_fractional_ramp_bank_top test passed");
    end else begin
      $display("delayed_fractional_ramp_bank_top test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/dfrb_pkg.sv
sv/dfrb_ctrl.sv
sv/dfrb_dpath.sv
sv/delayed_fractional_ramp_bank_top.sv
bench/delayed_fractional_ramp_bank_top_tb.sv
